FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge, reset included.
`define SSPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Check on clock edges outside reset.
`define SSPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

FILE: hdl/sspq_pkg.sv
// Shared types, codes and defaults of the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none

package sspq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int QUEUE_DEPTH   = 2;

  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int RANK_W   = 16;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SHOW   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_DELETE,
    OP_SHOW
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
    logic [RANK_W-1:0]         rank;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_SHOW
  } back_state_t;

endpackage

`default_nettype wire

FILE: hdl/sspq_channels.sv
// Valid/ready channel interfaces for commands in and results out.
`timescale 1ns / 1ps
`default_nettype none

interface sspq_item_if;
  logic                                valid;
  logic                                ready;
  logic [sspq_pkg::CMD_W-1:0]          command;
  logic signed [sspq_pkg::VALUE_W-1:0] item_value;
  logic [sspq_pkg::RANK_W-1:0]         item_rank;

  modport source (output valid, command, item_value, item_rank, input ready);
  modport sink   (input valid, command, item_value, item_rank, output ready);
endinterface

interface sspq_result_if;
  logic                                valid;
  logic                                ready;
  logic [sspq_pkg::STATUS_W-1:0]       status;
  logic signed [sspq_pkg::VALUE_W-1:0] out_value;
  logic [sspq_pkg::RANK_W-1:0]         out_rank;
  logic                                last;

  modport source (output valid, status, out_value, out_rank, last, input ready);
  modport sink   (input valid, status, out_value, out_rank, last, output ready);
endinterface

`default_nettype wire

FILE: hdl/stable_sorted_priority_queue_top.sv
// Sorted priority queue, smallest rank first, equal ranks in arrival order.
// Commands enter through a two-entry queue and are carried out by a register
// store of DEPTH slots with a comparator per slot. Insert and delete sustain
// one command per cycle while the result channel is ready; the result is
// registered and presented in the cycle after the command is taken, and is
// held until the result channel is ready. Show first moves the store into its
// show state; then, while the result channel is ready, the store rotates one
// slot per cycle to bring each entry to the front. An insert on a full store
// and a delete or show on an empty one give a single result with an error
// status. Command code 3 is taken and dropped with no result.
`timescale 1ns / 1ps
`default_nettype none

module stable_sorted_priority_queue_top #(
  parameter int DEPTH = sspq_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  sspq_item_if.sink     items,
  sspq_result_if.source results
);

  logic           push_valid;
  logic           push_ready;
  sspq_pkg::cmd_t push_cmd;
  logic           pop_valid;
  logic           pop_ready;
  sspq_pkg::cmd_t pop_cmd;

  sspq_front u_front (
    .items      (items),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  sspq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  sspq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_cmd),
    .results   (results)
  );

endmodule

`default_nettype wire

FILE: hdl/sspq_front.sv
// Front end: decode incoming commands and drop undefined codes.
`timescale 1ns / 1ps
`default_nettype none

module sspq_front (
  sspq_item_if.sink        items,
  output logic             push_valid,
  input  logic             push_ready,
  output sspq_pkg::cmd_t   push_cmd
);

  logic cmd_known;

  always_comb begin
    push_cmd.value = items.item_value;
    push_cmd.rank  = items.item_rank;
    push_cmd.op    = sspq_pkg::OP_INSERT;
    cmd_known      = 1'b1;
    case (items.command)
      sspq_pkg::CMD_INSERT: push_cmd.op = sspq_pkg::OP_INSERT;
      sspq_pkg::CMD_DELETE: push_cmd.op = sspq_pkg::OP_DELETE;
      sspq_pkg::CMD_SHOW:   push_cmd.op = sspq_pkg::OP_SHOW;
      default:              cmd_known   = 1'b0;
    endcase
  end

  assign items.ready = push_ready;
  assign push_valid  = items.valid && cmd_known;

endmodule

`default_nettype wire

FILE: hdl/sspq_queue.sv
// Short command queue between the front end and the sorted store.
`timescale 1ns / 1ps
`default_nettype none

module sspq_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  sspq_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output sspq_pkg::cmd_t pop_cmd
);

  localparam int QD = sspq_pkg::QUEUE_DEPTH;
  localparam int PW = (QD > 1) ? $clog2(QD) : 1;
  localparam int FW = $clog2(QD + 1);

  sspq_pkg::cmd_t slots [QD];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [FW-1:0]  fill;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (fill != FW'(QD));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QD - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QD - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + FW'(do_push) - FW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sspq_back.sv
// Back end: sorted register store with parallel compare, shift and show sequencer.
`timescale 1ns / 1ps
`default_nettype none

module sspq_back #(
  parameter int DEPTH = sspq_pkg::DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  sspq_pkg::cmd_t   cmd,
  sspq_result_if.source    results
);

  localparam int CW = $clog2(DEPTH + 1);

  logic signed [sspq_pkg::VALUE_W-1:0] slot_values [DEPTH];
  logic [sspq_pkg::RANK_W-1:0]         slot_ranks  [DEPTH];
  logic [DEPTH-1:0]                    le;
  logic [CW-1:0]                       entry_count;
  logic [CW-1:0]                       show_pos;

  sspq_pkg::back_state_t state;
  sspq_pkg::back_state_t state_next;

  logic                                res_valid;
  logic [sspq_pkg::STATUS_W-1:0]       res_status;
  logic signed [sspq_pkg::VALUE_W-1:0] res_value;
  logic [sspq_pkg::RANK_W-1:0]         res_rank;
  logic                                res_last;

  logic                                out_free;
  logic                                is_full;
  logic                                is_empty;
  logic                                show_final;

  logic                                emit;
  logic [sspq_pkg::STATUS_W-1:0]       emit_status;
  logic signed [sspq_pkg::VALUE_W-1:0] emit_value;
  logic [sspq_pkg::RANK_W-1:0]         emit_rank;
  logic                                emit_last;
  logic                                do_insert;
  logic                                do_delete;
  logic                                do_rotate;

  assign out_free   = !res_valid || results.ready;
  assign is_full    = (entry_count == CW'(DEPTH));
  assign is_empty   = (entry_count == '0);
  assign show_final = (show_pos == (entry_count - CW'(1)));

  always_comb begin
    state_next = state;
    case (state)
      sspq_pkg::BK_IDLE: begin
        if (cmd_valid && out_free && (cmd.op == sspq_pkg::OP_SHOW) && !is_empty) begin
          state_next = sspq_pkg::BK_SHOW;
        end
      end
      sspq_pkg::BK_SHOW: begin
        if (out_free && show_final) begin
          state_next = sspq_pkg::BK_IDLE;
        end
      end
      default: state_next = sspq_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready   = 1'b0;
    emit        = 1'b0;
    emit_status = sspq_pkg::ST_OK;
    emit_value  = '0;
    emit_rank   = '0;
    emit_last   = 1'b1;
    do_insert   = 1'b0;
    do_delete   = 1'b0;
    do_rotate   = 1'b0;
    case (state)
      sspq_pkg::BK_IDLE: begin
        if (cmd_valid && out_free) begin
          case (cmd.op)
            sspq_pkg::OP_INSERT: begin
              cmd_ready = 1'b1;
              emit      = 1'b1;
              if (is_full) begin
                emit_status = sspq_pkg::ST_FULL;
              end else begin
                do_insert = 1'b1;
              end
            end
            sspq_pkg::OP_DELETE: begin
              cmd_ready = 1'b1;
              emit      = 1'b1;
              if (is_empty) begin
                emit_status = sspq_pkg::ST_EMPTY;
              end else begin
                do_delete  = 1'b1;
                emit_value = slot_values[0];
                emit_rank  = slot_ranks[0];
              end
            end
            sspq_pkg::OP_SHOW: begin
              if (is_empty) begin
                cmd_ready   = 1'b1;
                emit        = 1'b1;
                emit_status = sspq_pkg::ST_EMPTY;
              end
            end
            default: cmd_ready = 1'b1;
          endcase
        end
      end
      sspq_pkg::BK_SHOW: begin
        if (out_free) begin
          emit       = 1'b1;
          do_rotate  = 1'b1;
          emit_value = slot_values[0];
          emit_rank  = slot_ranks[0];
          emit_last  = show_final;
          cmd_ready  = show_final;
        end
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sspq_pkg::BK_IDLE;
      entry_count <= '0;
      show_pos    <= '0;
      res_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (do_insert) begin
        entry_count <= entry_count + CW'(1);
      end else if (do_delete) begin
        entry_count <= entry_count - CW'(1);
      end
      if (state == sspq_pkg::BK_IDLE) begin
        show_pos <= '0;
      end else if (do_rotate) begin
        show_pos <= show_pos + CW'(1);
      end
      if (emit) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_status <= emit_status;
      res_value  <= emit_value;
      res_rank   <= emit_rank;
      res_last   <= emit_last;
    end
  end

  assign results.valid     = res_valid;
  assign results.status    = res_status;
  assign results.out_value = res_value;
  assign results.out_rank  = res_rank;
  assign results.last      = res_last;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [sspq_pkg::VALUE_W-1:0] cell_value;
    logic [sspq_pkg::RANK_W-1:0]         cell_rank;
    logic signed [sspq_pkg::VALUE_W-1:0] up_value;
    logic [sspq_pkg::RANK_W-1:0]         up_rank;
    logic signed [sspq_pkg::VALUE_W-1:0] dn_value;
    logic [sspq_pkg::RANK_W-1:0]         dn_rank;
    logic                                le_prev;
    logic                                occupied;
    logic                                tail;

    assign occupied = (CW'(g) < entry_count);
    assign tail     = (CW'(g) == (entry_count - CW'(1)));
    assign le[g]    = occupied && (cell_rank <= cmd.rank);

    if (g == DEPTH - 1) begin : g_top
      assign up_value = cell_value;
      assign up_rank  = cell_rank;
    end else begin : g_mid
      assign up_value = slot_values[g + 1];
      assign up_rank  = slot_ranks[g + 1];
    end

    if (g == 0) begin : g_front
      assign dn_value = cmd.value;
      assign dn_rank  = cmd.rank;
      assign le_prev  = 1'b1;
    end else begin : g_rest
      assign dn_value = slot_values[g - 1];
      assign dn_rank  = slot_ranks[g - 1];
      assign le_prev  = le[g - 1];
    end

    always_ff @(posedge clk) begin
      if (do_insert && !le[g]) begin
        cell_value <= le_prev ? cmd.value : dn_value;
        cell_rank  <= le_prev ? cmd.rank : dn_rank;
      end else if (do_delete) begin
        cell_value <= up_value;
        cell_rank  <= up_rank;
      end else if (do_rotate && occupied) begin
        cell_value <= tail ? slot_values[0] : up_value;
        cell_rank  <= tail ? slot_ranks[0] : up_rank;
      end
    end

    assign slot_values[g] = cell_value;
    assign slot_ranks[g]  = cell_rank;
  end

endmodule

`default_nettype wire

FILE: hdl/sspq_checker.sv
// Port-level checks on the result channel of the priority queue, with bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sspq_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [sspq_pkg::STATUS_W-1:0]       out_status,
  input logic signed [sspq_pkg::VALUE_W-1:0] out_value,
  input logic [sspq_pkg::RANK_W-1:0]         out_rank,
  input logic                                out_last
);

  `SSPQ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_value) && $stable(out_rank) && $stable(out_last), "stalled result changed")
  `SSPQ_ASSERT_ALWAYS(a_reset_quiet, rst |=> !out_valid, "result valid right after reset")
  `SSPQ_ASSERT(a_error_single, out_valid && (out_status != sspq_pkg::ST_OK) |-> out_last && (out_value == '0) && (out_rank == '0), "error result not a lone empty transfer")

endmodule

bind stable_sorted_priority_queue_top sspq_checker u_sspq_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_status (results.status),
  .out_value  (results.out_value),
  .out_rank   (results.out_rank),
  .out_last   (results.last)
);

`default_nettype wire

FILE: tb/tb_stable_sorted_priority_queue_top.sv
// Testbench for the stable sorted priority queue: checks every result against its own queue model.
`timescale 1ns / 1ps

module tb_stable_sorted_priority_queue_top;
  import sspq_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 435;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] value;
    logic [RANK_W-1:0]         rank;
    logic                      last;
  } reply_t;

  class rank_queue_tracker;
    int unsigned               depth;
    logic signed [VALUE_W-1:0] held_values[$];
    logic [RANK_W-1:0]         held_ranks[$];
    reply_t                    pending_replies[$];
    int unsigned               failures;

    function new(int unsigned depth_i);
      depth = depth_i;
      failures = 0;
    endfunction

    function int unsigned held_count();
      return held_ranks.size();
    endfunction

    function void add_reply(logic [STATUS_W-1:0] status, logic signed [VALUE_W-1:0] value,
                            logic [RANK_W-1:0] rank, logic last);
      reply_t r;
      r.status = status;
      r.value  = value;
      r.rank   = rank;
      r.last   = last;
      pending_replies.push_back(r);
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic signed [VALUE_W-1:0] value,
                               logic [RANK_W-1:0] rank);
      int unsigned pos;
      if (cmd == CMD_INSERT) begin
        if (held_ranks.size() >= depth) begin
          add_reply(ST_FULL, '0, '0, 1'b1);
        end else begin
          pos = 0;
          while (pos < held_ranks.size() && held_ranks[pos] <= rank) pos++;
          held_values.insert(pos, value);
          held_ranks.insert(pos, rank);
          add_reply(ST_OK, '0, '0, 1'b1);
        end
      end else if (cmd == CMD_DELETE) begin
        if (held_ranks.size() == 0)
          add_reply(ST_EMPTY, '0, '0, 1'b1);
        else
          add_reply(ST_OK, held_values.pop_front(), held_ranks.pop_front(), 1'b1);
      end else if (cmd == CMD_SHOW) begin
        if (held_ranks.size() == 0) begin
          add_reply(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < held_ranks.size(); i++)
            add_reply(ST_OK, held_values[i], held_ranks[i], i + 1 == held_ranks.size());
        end
      end
    endfunction

    function void check_reply(logic [STATUS_W-1:0] status, logic signed [VALUE_W-1:0] value,
                              logic [RANK_W-1:0] rank, logic last);
      reply_t want;
      if (pending_replies.size() == 0) begin
        $error("unexpected result: status=%0d out_value=%0d out_rank=%0d last=%0b",
               status, value, rank, last);
        failures++;
        return;
      end
      want = pending_replies.pop_front();
      if (status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, status);
        failures++;
      end
      if (value !== want.value) begin
        $error("out_value mismatch: expected %0d, actual %0d", want.value, value);
        failures++;
      end
      if (rank !== want.rank) begin
        $error("out_rank mismatch: expected %0d, actual %0d", want.rank, rank);
        failures++;
      end
      if (last !== want.last) begin
        $error("last mismatch: expected %0b, actual %0b", want.last, last);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   idling_on;

  rank_queue_tracker tracker;

  sspq_item_if   item_ch ();
  sspq_result_if result_ch ();

  stable_sorted_priority_queue_top #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .items(item_ch),
    .results(result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_500_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_command(input logic [CMD_W-1:0] cmd,
                              input logic signed [VALUE_W-1:0] value,
                              input logic [RANK_W-1:0] rank);
    int gap;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      item_ch.valid = 1'b0;
      gap = $urandom_range(1, 17);
      repeat (gap) @(negedge clk);
    end
    item_ch.valid      = 1'b1;
    item_ch.command    = cmd;
    item_ch.item_value = value;
    item_ch.item_rank  = rank;
    do @(posedge clk); while (!item_ch.ready);
    tracker.note_command(cmd, value, rank);
    @(negedge clk);
  endtask

  // hold ready low in random bursts while idling is on
  initial begin
    int stall;
    result_ch.ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0 && idling_on) begin
        result_ch.ready = 1'b0;
        stall--;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        result_ch.ready = 1'b0;
        stall = $urandom_range(1, 17) - 1;
      end else begin
        result_ch.ready = 1'b1;
        stall = 0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      tracker.check_reply(result_ch.status, result_ch.out_value, result_ch.out_rank,
                          result_ch.last);
  end

  initial begin
    int                        sent;
    int                        next_switch;
    int                        roll;
    bit                        filling;
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] value;
    logic [RANK_W-1:0]         rank;
    tracker = new(DEPTH);
    rst = 1'b1;
    idling_on = 1'b1;
    item_ch.valid      = 1'b0;
    item_ch.command    = CMD_INSERT;
    item_ch.item_value = '0;
    item_ch.item_rank  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    send_command(CMD_DELETE, 32'sh1234_5678, 16'hffff);
    send_command(CMD_SHOW, -32'sd1, 16'h0000);
    send_command(CMD_UNUSED, 32'sh7fff_ffff, 16'hffff);
    send_command(CMD_INSERT, 32'sh7fff_ffff, 16'hffff);
    send_command(CMD_INSERT, 32'sh8000_0000, 16'h0000);
    send_command(CMD_INSERT, 32'sh0000_0000, 16'hffff);
    send_command(CMD_INSERT, -32'sd1, 16'h8000);
    send_command(CMD_SHOW, 32'sh0, 16'h0);
    send_command(CMD_DELETE, -32'sd1, 16'hffff);
    for (int i = 0; i < 13; i++)
      send_command(CMD_INSERT, VALUE_W'(i * 1000 - 6000), RANK_W'(i % 3) + 16'h7fff);
    send_command(CMD_INSERT, 32'sh5555_aaaa, 16'h0000);
    send_command(CMD_SHOW, 32'shaaaa_5555, 16'h5555);
    send_command(CMD_DELETE, 32'sh0, 16'h0);

    filling = 1'b1;
    sent = 0;
    next_switch = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= next_switch) begin
        idling_on = $urandom_range(0, 3) != 0;
        next_switch += 40;
      end
      if (sent >= RANDOM_ITEMS - 60) idling_on = 1'b0;
      if (tracker.held_count() >= DEPTH && $urandom_range(0, 2) == 0) filling = 1'b0;
      if (tracker.held_count() == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;

      roll = $urandom_range(0, 99);
      if (roll < 3)
        cmd = CMD_UNUSED;
      else if (roll < 10)
        cmd = CMD_SHOW;
      else if ($urandom_range(0, 9) < (filling ? 7 : 3))
        cmd = CMD_INSERT;
      else
        cmd = CMD_DELETE;

      case ($urandom_range(0, 5))
        0: value = 32'sh8000_0000;
        1: value = 32'sh7fff_ffff;
        2: value = VALUE_W'($urandom_range(0, 15)) - 8;
        default: value = $urandom;
      endcase
      case ($urandom_range(0, 5))
        0: rank = 16'h0000;
        1: rank = 16'hffff;
        2, 3: rank = RANK_W'($urandom_range(0, 3));
        default: rank = RANK_W'($urandom_range(0, 65535));
      endcase

      send_command(cmd, value, rank);
      if (cmd != CMD_UNUSED) sent++;
    end
    item_ch.valid = 1'b0;

    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.failures == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
